// ===== hw/rtl/ipp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipp_pkg
// Shared constants, codes and an arithmetic helper for the palette lookup and
// premultiply pipeline.
// ----------------------------------------------------------------------------
package ipp_pkg;

    // palette geometry
    localparam int PALETTE_ENTRIES = 256;
    localparam int ADDR_W          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CHAN_W          = 8;
    localparam int ENTRY_W         = 4 * CHAN_W;
    localparam int PROD_W          = 2 * CHAN_W;

    // item kinds carried on tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // palette entry packing, alpha in the low byte
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } ipp_entry_t;

    // floor(p / 255) for any 16-bit product of two 8-bit values
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + (PROD_W+1)'(1) + (PROD_W+1)'(p[PROD_W-1:CHAN_W]);
        return s[PROD_W-1:CHAN_W];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ipp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data and a read enable that holds the output.
// ----------------------------------------------------------------------------
module ipp_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_pixel_premultiply.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_pixel_premultiply
// Palette lookup turning 8-bit indices into premultiplied RGBA pixels.
// ----------------------------------------------------------------------------
// Takes one item per clock on the slave stream while tready is high. A load
// item (tuser = 0) writes one RGBA entry into the palette RAM and produces
// nothing; a pixel item (tuser = 1) reads its entry and emits floor(A*C/255)
// for each color and floor(A*A/255) for alpha, with tlast copied through. A
// pixel result passes through registered stages for the palette RAM read,
// the 8x8 multipliers and the divide by 255, in that order. The pipeline
// stalls only from the master side; bubbles are squeezed out so input is
// still taken while a finished result waits. A pixel may name an entry loaded
// by the item just before it. Entries never loaded read as undefined; an
// index beyond the palette reads as transparent black.
module indexed_pixel_premultiply
    import ipp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // color_index, red_in, green_in, blue_in, alpha_in
    input  wire logic        s_axis_tuser,  // cmd
    input  wire logic        s_axis_tlast,  // last_pixel
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic             m_axis_tlast   // end_of_rect
);

    localparam logic [CHAN_W:0] INDEX_LIMIT = (CHAN_W+1)'(PALETTE_ENTRIES);

    // input unpacking
    logic [CHAN_W-1:0] color_index;
    ipp_entry_t        load_entry;
    logic              in_accept;
    logic              in_range;

    assign color_index      = s_axis_tdata[7:0];
    assign load_entry.red   = s_axis_tdata[15:8];
    assign load_entry.green = s_axis_tdata[23:16];
    assign load_entry.blue  = s_axis_tdata[31:24];
    assign load_entry.alpha = s_axis_tdata[39:32];
    assign in_accept        = s_axis_tvalid && s_axis_tready;
    assign in_range         = ({1'b0, color_index} < INDEX_LIMIT);

    // stage valids and advance enables
    logic rd_valid_reg;
    logic mul_valid_reg;
    logic out_valid_reg;
    logic out_en;
    logic mul_en;
    logic rd_en;

    assign out_en        = !out_valid_reg || m_axis_tready;
    assign mul_en        = !mul_valid_reg || out_en;
    assign rd_en         = !rd_valid_reg || mul_en;
    assign s_axis_tready = rd_en;

    // palette memory
    logic [ENTRY_W-1:0] rd_word;
    ipp_entry_t         rd_entry;

    ipp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (in_accept && (s_axis_tuser == CMD_LOAD) && in_range),
        .waddr (color_index[ADDR_W-1:0]),
        .wdata (load_entry),
        .re    (rd_en),
        .raddr (color_index[ADDR_W-1:0]),
        .rdata (rd_word)
    );

    assign rd_entry = ipp_entry_t'(rd_word);

    // read stage side info
    logic rd_last_reg;
    logic rd_hit_reg;

    // multiply stage
    logic [PROD_W-1:0] prod_r_reg;
    logic [PROD_W-1:0] prod_g_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic [PROD_W-1:0] prod_a_reg;
    logic              mul_last_reg;
    logic [CHAN_W-1:0] alpha_eff;

    // out-of-range pixels behave as an all-zero entry
    assign alpha_eff = rd_hit_reg ? rd_entry.alpha : '0;

    // output stage
    ipp_entry_t out_pix_reg;
    logic       out_last_reg;

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= in_accept && (s_axis_tuser == CMD_PIXEL);
            end
            if (mul_en)
            begin
                mul_valid_reg <= rd_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_last_reg <= s_axis_tlast;
            rd_hit_reg  <= in_range;
        end
        if (mul_en)
        begin
            prod_r_reg   <= alpha_eff * rd_entry.red;
            prod_g_reg   <= alpha_eff * rd_entry.green;
            prod_b_reg   <= alpha_eff * rd_entry.blue;
            prod_a_reg   <= alpha_eff * rd_entry.alpha;
            mul_last_reg <= rd_last_reg;
        end
        if (out_en)
        begin
            out_pix_reg.red   <= div255(prod_r_reg);
            out_pix_reg.green <= div255(prod_g_reg);
            out_pix_reg.blue  <= div255(prod_b_reg);
            out_pix_reg.alpha <= div255(prod_a_reg);
            out_last_reg      <= mul_last_reg;
        end
    end

    // master side
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_pix_reg.alpha, out_pix_reg.blue,
                            out_pix_reg.green, out_pix_reg.red};
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire
